// ===== hdl/rcmg_pkg.sv =====
package rcmg_pkg;

    localparam int GAMMA_SEGMENTS_DEF      = 1024;
    localparam int COEFF_FRACTION_BITS_DEF = 12;
    localparam int PIXEL_BITS_DEF          = 16;

    localparam int CHAN_W    = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = CHAN_W + COEF_W + 1;
    localparam int SUM_W     = PROD_W + 2;

    // Input register, three product stages, two gamma stages.
    localparam int PIPE_DEPTH = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFFS_RED   = 2'd0,
        REG_COEFFS_GREEN = 2'd1,
        REG_COEFFS_BLUE  = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] COEFFS_RED_RST   = 48'd4096;
    localparam logic [CFG_W-1:0] COEFFS_GREEN_RST = 48'd4096 << 16;
    localparam logic [CFG_W-1:0] COEFFS_BLUE_RST  = 48'd4096 << 32;

    // Smallest shift s with segs * 2^s >= 2^pix_bits.
    function automatic int seg_shift(int segs, int pix_bits);
        int s;
        s = 0;
        while (s < 31 && (longint'(segs) << s) < (longint'(1) << pix_bits))
            s++;
        return s;
    endfunction

    // One point of the curve round(2^P * (idx/segs)^(5/9)), clamped to 2^P-1.
    // Exact test: (2y-1)^9 * segs^5 <= 2^(9P+9) * idx^5, searched over y.
    function automatic logic [15:0] gamma_point(int pix_bits, int segs, int idx);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] nf;
        logic [255:0] base;
        int lo;
        int hi;
        int mid;
        int k;
        nf  = 256'd1;
        rhs = 256'd1;
        for (k = 0; k < 5; k++)
        begin
            nf  = nf * 256'(segs);
            rhs = rhs * 256'(idx);
        end
        rhs = rhs << (9 * pix_bits + 9);
        lo = 0;
        hi = 1 << pix_bits;
        while (lo < hi)
        begin
            mid  = (lo + hi + 1) / 2;
            base = 256'(2 * mid - 1);
            lhs  = base;
            for (k = 0; k < 8; k++)
                lhs = lhs * base;
            lhs = lhs * nf;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (lo > (1 << pix_bits) - 1)
            lo = (1 << pix_bits) - 1;
        return 16'(lo);
    endfunction

endpackage

// ===== hdl/rgb_color_matrix_gamma.sv =====
// Colour correction matrix followed by the ProPhoto gamma curve, one pixel per clock.
// Each output channel is the rounded, clamped dot product of the input pixel with three
// signed Q4.12 coefficients, then encoded by a linear segment near black and a curve
// table of GAMMA_SEGMENTS+1 points with linear interpolation above it. The pipeline is
// six register stages deep (input, products, sum, clamp, table read, interpolation); it
// accepts a new beat every cycle while the output beat is taken or the output register
// is empty.
// The coefficient registers reset to identity and are written through the cfg port,
// which is always ready; write them only while no pixel is in flight.
module rgb_color_matrix_gamma
    import rcmg_pkg::*;
#(
    parameter int GAMMA_SEGMENTS      = GAMMA_SEGMENTS_DEF,
    parameter int COEFF_FRACTION_BITS = COEFF_FRACTION_BITS_DEF,
    parameter int PIXEL_BITS          = PIXEL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,  // red_in, green_in, blue_in

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata   // red_out, green_out, blue_out
);

    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (COEFF_FRACTION_BITS - 1);
    localparam logic [SUM_W-1:0] PIX_MAX = SUM_W'((1 << PIXEL_BITS) - 1);

    logic [2:0][CFG_W-1:0]                     coeffs_reg;
    logic [2:0][CHAN_W-1:0]                    pix_reg;
    logic signed [PROD_W-1:0]                  prod_reg [3][3];
    logic signed [SUM_W-1:0]                   sum_reg  [3];
    logic [PIXEL_BITS-1:0]                     clamp_reg [3];
    logic [PIXEL_BITS-1:0]                     clamp_next [3];
    logic [SUM_W-1:0]                          quo [3];
    logic [CHAN_W-1:0]                         gamma_y [3];
    logic [PIPE_DEPTH-1:0]                     valid_reg;
    logic                                      advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg[0] <= COEFFS_RED_RST;
            coeffs_reg[1] <= COEFFS_GREEN_RST;
            coeffs_reg[2] <= COEFFS_BLUE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COEFFS_RED:   coeffs_reg[0] <= cfg_data;
                REG_COEFFS_GREEN: coeffs_reg[1] <= cfg_data;
                REG_COEFFS_BLUE:  coeffs_reg[2] <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the output register can take a beat.
    assign advance       = !valid_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg <= s_axis_tdata;
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                    prod_reg[c][k] <= $signed(coeffs_reg[c][COEF_W*k +: COEF_W])
                                      * $signed({1'b0, pix_reg[k]});
                sum_reg[c]   <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                                + SUM_W'(prod_reg[c][2]) + ROUND;
                clamp_reg[c] <= clamp_next[c];
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            quo[c] = SUM_W'(sum_reg[c] >>> COEFF_FRACTION_BITS);
            if (sum_reg[c][SUM_W-1])
                clamp_next[c] = '0;
            else if (quo[c] > PIX_MAX)
                clamp_next[c] = PIXEL_BITS'(PIX_MAX);
            else
                clamp_next[c] = PIXEL_BITS'(quo[c]);
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_gamma
        rcmg_gamma #(
            .PIXEL_BITS     (PIXEL_BITS),
            .GAMMA_SEGMENTS (GAMMA_SEGMENTS)
        ) u_gamma (
            .clk (clk),
            .en  (advance),
            .x   (clamp_reg[c]),
            .y   (gamma_y[c])
        );
    end

    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = {gamma_y[2], gamma_y[1], gamma_y[0]};

endmodule

// ===== hdl/rcmg_gamma.sv =====
module rcmg_gamma
    import rcmg_pkg::*;
#(
    parameter int PIXEL_BITS     = PIXEL_BITS_DEF,
    parameter int GAMMA_SEGMENTS = GAMMA_SEGMENTS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [PIXEL_BITS-1:0] x,
    output logic [CHAN_W-1:0]     y
);

    localparam int SHIFT     = seg_shift(GAMMA_SEGMENTS, PIXEL_BITS);
    localparam int FRAC_W    = (SHIFT > 0) ? SHIFT : 1;
    localparam int IDX_W     = $clog2(GAMMA_SEGMENTS + 1);
    localparam int LIN_LIMIT = 1 << (PIXEL_BITS - 9);
    localparam logic [PIXEL_BITS:0] PIX_MAX = (PIXEL_BITS + 1)'((1 << PIXEL_BITS) - 1);

    typedef logic [GAMMA_SEGMENTS:0][PIXEL_BITS-1:0] rom_t;

    function automatic rom_t build_rom();
        rom_t r;
        for (int j = 0; j <= GAMMA_SEGMENTS; j++)
            r[j] = PIXEL_BITS'(gamma_point(PIXEL_BITS, GAMMA_SEGMENTS, j));
        return r;
    endfunction

    localparam rom_t GAMMA_ROM = build_rom();

    logic [PIXEL_BITS-1:0]        seg_full;
    logic [IDX_W-1:0]             seg_idx;
    logic [FRAC_W-1:0]            frac;
    logic [PIXEL_BITS-1:0]        lo_reg;
    logic [PIXEL_BITS-1:0]        hi_reg;
    logic [FRAC_W-1:0]            frac_reg;
    logic                         lin_reg;
    logic [CHAN_W-1:0]            lin_val_reg;
    logic [PIXEL_BITS-1:0]        diff;
    logic [PIXEL_BITS+FRAC_W-1:0] prod;
    logic [PIXEL_BITS-1:0]        step;
    logic [PIXEL_BITS:0]          interp;
    logic [CHAN_W-1:0]            y_next;
    logic [CHAN_W-1:0]            y_reg;

    always_comb
    begin
        seg_full = x >> SHIFT;
        if (32'(seg_full) >= GAMMA_SEGMENTS)
            seg_idx = IDX_W'(GAMMA_SEGMENTS - 1);
        else
            seg_idx = IDX_W'(seg_full);
        frac = (SHIFT == 0) ? '0 : x[FRAC_W-1:0];
    end

    // Both neighbouring curve points are fetched in the same cycle.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg      <= GAMMA_ROM[seg_idx];
            hi_reg      <= GAMMA_ROM[seg_idx + 1'b1];
            frac_reg    <= frac;
            lin_reg     <= (32'(x) < LIN_LIMIT);
            lin_val_reg <= CHAN_W'({x, 4'b0000});
        end
    end

    always_comb
    begin
        diff   = (hi_reg >= lo_reg) ? (hi_reg - lo_reg) : '0;
        prod   = (PIXEL_BITS + FRAC_W)'(diff) * (PIXEL_BITS + FRAC_W)'(frac_reg);
        step   = PIXEL_BITS'(prod >> SHIFT);
        interp = {1'b0, lo_reg} + {1'b0, step};
        if (lin_reg)
            y_next = lin_val_reg;
        else if (interp > PIX_MAX)
            y_next = CHAN_W'(PIX_MAX);
        else
            y_next = CHAN_W'(interp);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

// ===== hdl/rcmg_checker.sv =====
module rcmg_checker
    import rcmg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [47:0]          m_axis_tdata
);

    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (s_axis_tvalid && s_axis_tready)
            inflight_next = inflight_next + 4'd1;
        if (m_axis_tvalid && m_axis_tready)
            inflight_next = inflight_next - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // A held output beat keeps its pixel.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // An empty output register never holds back the input side.
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Every output beat comes from an accepted input beat.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 4'd0)
        else $error("output beat without a pixel in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rgb_color_matrix_gamma rcmg_checker u_rcmg_checker (.*);

// ===== tb/sv/tb_rgb_color_matrix_gamma.sv =====
module tb_rgb_color_matrix_gamma;
    import rcmg_pkg::*;

    localparam int PIX_BITS     = PIXEL_BITS_DEF;
    localparam int PIX_MAX      = (1 << PIX_BITS) - 1;
    localparam int FRAC_BITS    = COEFF_FRACTION_BITS_DEF;
    localparam int ROUND_HALF   = 1 << (FRAC_BITS - 1);
    localparam int SEGMENTS     = GAMMA_SEGMENTS_DEF;
    localparam int SEG_SHIFT    = PIX_BITS - $clog2(SEGMENTS);
    localparam int SEG_MASK     = (1 << SEG_SHIFT) - 1;
    localparam int LINEAR_LIMIT = 1 << (PIX_BITS - 9);
    // Curve point y satisfies (2y-1)^9 * N^5 <= 2^(9P+9) * i^5; N is a power of two,
    // so its fifth power folds into the shift on the right-hand side.
    localparam int CURVE_SHIFT  = 9 * PIX_BITS + 9 - 5 * $clog2(SEGMENTS);
    localparam int ROUNDS       = 10;
    localparam int PIXELS_PER_ROUND = 95;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } coeff_write_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [47:0]          s_axis_tdata  = '0;  // red_in, green_in, blue_in
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;        // red_out, green_out, blue_out

    pixel_t       pixel_q [$];
    pixel_t       graded_q [$];
    coeff_write_t coeff_q [$];

    logic [CFG_W-1:0] matrix_rows [3] = '{COEFFS_RED_RST, COEFFS_GREEN_RST, COEFFS_BLUE_RST};
    int               curve_pts [0:SEGMENTS];

    bit     idle_on     = 1'b0;
    int     src_hold    = 0;
    int     sink_hold   = 0;
    int     errors      = 0;
    int     pixels_seen = 0;
    int     settings    = 1;
    pixel_t want_px;

    rgb_color_matrix_gamma dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit curve_reaches(int y, int idx);
        logic [255:0] lhs;
        logic [255:0] rhs;
        logic [255:0] base;
        int k;
        if (y == 0)
            return 1'b1;
        base = 2 * y - 1;
        lhs  = base;
        for (k = 1; k < 9; k++)
            lhs = lhs * base;
        base = idx;
        rhs  = base;
        for (k = 1; k < 5; k++)
            rhs = rhs * base;
        rhs = rhs << CURVE_SHIFT;
        return lhs <= rhs;
    endfunction

    function automatic logic [CHAN_W-1:0] mix_channel(logic [CFG_W-1:0] row, pixel_t px);
        logic signed [COEF_W-1:0] c_r;
        logic signed [COEF_W-1:0] c_g;
        logic signed [COEF_W-1:0] c_b;
        longint acc;
        c_r = row[15:0];
        c_g = row[31:16];
        c_b = row[47:32];
        acc = longint'(c_r) * longint'(px.red) + longint'(c_g) * longint'(px.green)
            + longint'(c_b) * longint'(px.blue) + ROUND_HALF;
        if (acc < 0)
            return '0;
        acc = acc >>> FRAC_BITS;
        if (acc > PIX_MAX)
            return PIX_MAX[CHAN_W-1:0];
        return acc[CHAN_W-1:0];
    endfunction

    function automatic logic [CHAN_W-1:0] encode_gamma(logic [CHAN_W-1:0] x);
        int seg;
        int frac;
        int lo;
        int hi;
        int y;
        if (x < LINEAR_LIMIT)
            return x << 4;
        seg  = x >> SEG_SHIFT;
        frac = x & SEG_MASK;
        lo   = curve_pts[seg];
        hi   = curve_pts[seg + 1];
        y    = lo;
        if (hi >= lo)
            y = y + (((hi - lo) * frac) >> SEG_SHIFT);
        if (y > PIX_MAX)
            y = PIX_MAX;
        return y[CHAN_W-1:0];
    endfunction

    function automatic pixel_t grade_pixel(pixel_t px);
        pixel_t res;
        res.red   = encode_gamma(mix_channel(matrix_rows[0], px));
        res.green = encode_gamma(mix_channel(matrix_rows[1], px));
        res.blue  = encode_gamma(mix_channel(matrix_rows[2], px));
        return res;
    endfunction

    function automatic string channel_name(int ch);
        case (ch)
            0:       return "red_out";
            1:       return "green_out";
            default: return "blue_out";
        endcase
    endfunction

    // A plausible camera matrix: strong diagonal, small negative cross terms.
    function automatic logic [CFG_W-1:0] natural_row(int diag);
        logic [CFG_W-1:0] row;
        int v;
        for (int k = 0; k < 3; k++)
        begin
            if (k == diag)
                v = 4096 + $urandom_range(0, 6000);
            else
                v = -$urandom_range(0, 3000);
            row[16*k +: 16] = v[15:0];
        end
        return row;
    endfunction

    function automatic logic [CFG_W-1:0] random_row();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[CFG_W-1:0];
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2)
        begin
            // Near black, around the end of the linear segment.
            px.red   = 16'($urandom_range(0, 400));
            px.green = 16'($urandom_range(0, 400));
            px.blue  = 16'($urandom_range(0, 400));
        end
        else if (sel < 4)
        begin
            px.red   = 16'(PIX_MAX - $urandom_range(0, 600));
            px.green = 16'(PIX_MAX - $urandom_range(0, 600));
            px.blue  = 16'(PIX_MAX - $urandom_range(0, 600));
        end
        else
        begin
            px.red   = 16'($urandom());
            px.green = 16'($urandom());
            px.blue  = 16'($urandom());
        end
        return px;
    endfunction

    task automatic push_pixel(int r, int g, int b);
        pixel_t px;
        px.red   = r[15:0];
        px.green = g[15:0];
        px.blue  = b[15:0];
        pixel_q.push_back(px);
    endtask

    task automatic coeff_write(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        coeff_write_t w;
        w.index = index;
        w.value = value;
        coeff_q.push_back(w);
    endtask

    task automatic coeff_flush();
        while (coeff_q.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    task automatic load_matrix(logic [CFG_W-1:0] r, logic [CFG_W-1:0] g,
                               logic [CFG_W-1:0] b);
        coeff_write(REG_COEFFS_RED, r);
        coeff_write(REG_COEFFS_GREEN, g);
        coeff_write(REG_COEFFS_BLUE, b);
        coeff_flush();
        settings++;
    endtask

    // Waits until every pixel is out, then lets the pipeline run empty.
    task automatic drain();
        while (pixel_q.size() != 0 || s_axis_tvalid || graded_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_hold      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (src_hold > 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_hold      <= src_hold - 1;
            end
            else if (pixel_q.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                src_hold      <= $urandom_range(0, 9);
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_q.pop_front();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= 0;
        end
        else if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= $urandom_range(0, 9);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else if (!cfg_valid || cfg_ready)
        begin
            if (coeff_q.size() != 0)
            begin
                cfg_valid <= 1'b1;
                {cfg_index, cfg_data} <= coeff_q.pop_front();
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COEFFS_RED:   matrix_rows[0] = cfg_data;
                    REG_COEFFS_GREEN: matrix_rows[1] = cfg_data;
                    REG_COEFFS_BLUE:  matrix_rows[2] = cfg_data;
                    default:          ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                graded_q.push_back(grade_pixel(pixel_t'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (graded_q.size() == 0)
                begin
                    $error("output beat %h with no pixel outstanding", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want_px = graded_q.pop_front();
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        if (m_axis_tdata[16*ch +: 16] !== want_px[16*ch +: 16])
                        begin
                            $error("%s: expected %0d, got %0d", channel_name(ch),
                                   want_px[16*ch +: 16], m_axis_tdata[16*ch +: 16]);
                            errors++;
                        end
                    end
                    pixels_seen++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  y;
        real est;
        // The curve table is derived exactly: a floating-point first guess, then
        // nudged until the integer rounding test holds for y and fails for y+1.
        for (int i = 0; i <= SEGMENTS; i++)
        begin
            est = 65536.0 * ((i / real'(SEGMENTS)) ** (5.0 / 9.0));
            y   = $rtoi(est + 0.5);
            while (y > 0 && !curve_reaches(y, i))
                y--;
            while (y <= PIX_MAX && curve_reaches(y + 1, i))
                y++;
            curve_pts[i] = (y > PIX_MAX) ? PIX_MAX : y;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity matrix after reset: the output is the bare gamma curve.
        push_pixel(0, 0, 0);
        push_pixel(65535, 65535, 65535);
        push_pixel(127, 128, 129);
        push_pixel(1, 63, 64);
        push_pixel(65472, 65471, 4096);
        push_pixel(32768, 16384, 8192);
        push_pixel(255, 256, 1023);
        push_pixel(43690, 21845, 65534);
        drain();

        // A write to the unmapped index must leave the matrix alone.
        coeff_write(REG_UNMAPPED, random_row());
        coeff_flush();
        push_pixel(127, 128, 65535);
        push_pixel(200, 300, 400);
        drain();

        // Largest positive coefficients: bright pixels overflow and clamp.
        load_matrix(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
        push_pixel(65535, 65535, 65535);
        push_pixel(1, 0, 0);
        push_pixel(9, 9, 9);
        drain();

        // Most negative coefficients: sums go below zero and clamp to black.
        load_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
        push_pixel(65535, 65535, 65535);
        push_pixel(0, 0, 0);
        push_pixel(0, 0, 1);
        drain();

        load_matrix(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_pixel(1, 1, 1);
        push_pixel(65535, 0, 0);
        drain();

        // Half-weight terms exercise the rounding at exactly one half.
        load_matrix(48'h0000_0000_0800, 48'h0000_0800_0000, 48'hF800_0000_1000);
        push_pixel(1, 1, 1);
        push_pixel(3, 3, 3);
        push_pixel(4095, 4097, 2);
        drain();

        load_matrix('0, '0, '0);
        push_pixel(65535, 65535, 65535);
        drain();

        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            idle_on = (rnd < ROUNDS - 2) && (rnd != 3);
            if (rnd % 3 == 1)
                load_matrix(random_row(), random_row(), random_row());
            else
                load_matrix(natural_row(0), natural_row(1), natural_row(2));
            for (int n = 0; n < PIXELS_PER_ROUND; n++)
                pixel_q.push_back(random_pixel());
            drain();
        end

        $display("%0d pixels graded under %0d coefficient settings, from clamp extremes",
                 pixels_seen, settings);
        $display("to random and camera-like matrices, with stalls on both streams.");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
